FILE: rtl/ebalu_pkg.sv
// shared types and command codes for the eight-bit alu with status flags
package ebalu_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned WordW = 16;
    localparam int unsigned CmdW  = 4;
    localparam int unsigned ImmW  = 6;

    typedef enum logic [CmdW-1:0] {
        OP_ADD  = 4'd0,
        OP_ADC  = 4'd1,
        OP_SUB  = 4'd2,
        OP_SBC  = 4'd3,
        OP_CP   = 4'd4,
        OP_CPC  = 4'd5,
        OP_AND  = 4'd6,
        OP_OR   = 4'd7,
        OP_EOR  = 4'd8,
        OP_DEC  = 4'd9,
        OP_ADIW = 4'd10,
        OP_SBIW = 4'd11
    } alu_op_t;

    typedef struct packed {
        logic s;
        logic v;
        logic n;
        logic z;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [CmdW-1:0]  command;
        logic [WordW-1:0] left_operand;
        logic [ByteW-1:0] right_operand;
    } request_t;

    typedef struct packed {
        logic [WordW-1:0] result;
        logic             write_back;
        flags_t           flags;
    } answer_t;

endpackage

FILE: rtl/ebalu_cmd_if.sv
// request channel carrying one alu command and its operands
interface ebalu_cmd_if;
    import ebalu_pkg::*;

    logic             valid;
    logic             ready;
    logic [CmdW-1:0]  command;
    logic [WordW-1:0] left_operand;
    logic [ByteW-1:0] right_operand;

    modport source (output valid, output command, output left_operand,
                    output right_operand, input ready);
    modport sink   (input valid, input command, input left_operand,
                    input right_operand, output ready);
endinterface

FILE: rtl/ebalu_res_if.sv
// result channel carrying the alu result and the new flags
interface ebalu_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] result;
    logic        write_back;
    logic        carry_flag;
    logic        zero_flag;
    logic        negative_flag;
    logic        overflow_flag;
    logic        sign_flag;

    modport source (output valid, output result, output write_back,
                    output carry_flag, output zero_flag, output negative_flag,
                    output overflow_flag, output sign_flag, input ready);
    modport sink   (input valid, input result, input write_back,
                    input carry_flag, input zero_flag, input negative_flag,
                    input overflow_flag, input sign_flag, output ready);
endinterface

FILE: rtl/ebalu_core.sv
// combinational alu datapath and flag logic for one request
module ebalu_core
    import ebalu_pkg::*;
(
    input  request_t req,
    input  flags_t   flags_old,
    output answer_t  ans
);

    logic [ByteW-1:0] d;
    logic [ByteW-1:0] r;
    logic [ByteW-1:0] res8;
    logic [WordW-1:0] res16;
    logic [WordW-1:0] k;
    logic             ci;
    logic             d7;
    logic             r7;
    logic             q7;
    logic             dh7;
    logic             q15;
    logic             c;
    logic             z;
    logic             n;
    logic             v;
    alu_op_t          op;

    assign d   = req.left_operand[ByteW-1:0];
    assign r   = req.right_operand;
    assign d7  = d[ByteW-1];
    assign r7  = r[ByteW-1];
    assign dh7 = req.left_operand[WordW-1];
    assign k   = {{(WordW-ImmW){1'b0}}, req.right_operand[ImmW-1:0]};
    assign op  = alu_op_t'(req.command);

    always_comb
    begin
        ci    = 1'b0;
        res8  = '0;
        res16 = '0;
        q7    = 1'b0;
        q15   = 1'b0;
        c     = flags_old.c;
        z     = flags_old.z;
        n     = flags_old.n;
        v     = flags_old.v;
        ans.write_back = 1'b1;
        ans.flags      = flags_old;
        unique case (op)
            OP_ADD, OP_ADC:
            begin
                ci    = (op == OP_ADC) ? flags_old.c : 1'b0;
                res8  = d + r + {{(ByteW-1){1'b0}}, ci};
                q7    = res8[ByteW-1];
                c     = (d7 & r7) | (r7 & ~q7) | (~q7 & d7);
                v     = (d7 & r7 & ~q7) | (~d7 & ~r7 & q7);
                z     = (res8 == '0);
                n     = q7;
                res16 = {{(WordW-ByteW){1'b0}}, res8};
            end
            OP_SUB, OP_SBC, OP_CP, OP_CPC:
            begin
                ci    = (op == OP_SBC || op == OP_CPC) ? flags_old.c : 1'b0;
                res8  = d - r - {{(ByteW-1){1'b0}}, ci};
                q7    = res8[ByteW-1];
                c     = (~d7 & r7) | (r7 & q7) | (q7 & ~d7);
                v     = (d7 & ~r7 & ~q7) | (~d7 & r7 & q7);
                z     = (res8 == '0) & ((op == OP_SBC || op == OP_CPC) ? flags_old.z : 1'b1);
                n     = q7;
                res16 = {{(WordW-ByteW){1'b0}}, res8};
                ans.write_back = ~(op == OP_CP || op == OP_CPC);
            end
            OP_AND, OP_OR, OP_EOR:
            begin
                if (op == OP_AND)
                begin
                    res8 = d & r;
                end
                else if (op == OP_OR)
                begin
                    res8 = d | r;
                end
                else
                begin
                    res8 = d ^ r;
                end
                c     = flags_old.c;
                z     = (res8 == '0);
                n     = res8[ByteW-1];
                v     = 1'b0;
                res16 = {{(WordW-ByteW){1'b0}}, res8};
            end
            OP_DEC:
            begin
                res8  = d - 8'd1;
                c     = flags_old.c;
                z     = (res8 == '0);
                n     = res8[ByteW-1];
                v     = (res8 == 8'h7f);
                res16 = {{(WordW-ByteW){1'b0}}, res8};
            end
            OP_ADIW, OP_SBIW:
            begin
                if (op == OP_ADIW)
                begin
                    res16 = req.left_operand + k;
                    q15   = res16[WordW-1];
                    v     = ~dh7 & q15;
                    c     = ~q15 & dh7;
                end
                else
                begin
                    res16 = req.left_operand - k;
                    q15   = res16[WordW-1];
                    v     = dh7 & ~q15;
                    c     = q15 & ~dh7;
                end
                z = (res16 == '0);
                n = q15;
            end
            default:
            begin
                ans.write_back = 1'b0;
            end
        endcase
        ans.result = res16;
        if (req.command <= CmdW'(OP_SBIW))
        begin
            ans.flags.c = c;
            ans.flags.z = z;
            ans.flags.n = n;
            ans.flags.v = v;
            ans.flags.s = n ^ v;
        end
    end

endmodule

FILE: rtl/eight_bit_alu_with_status_flags_top.sv
// top level of the eight-bit alu: request stage, result stage and kept flags
//
//  channel  direction  payload                                        handshake
//  cmd      in         command, left_operand, right_operand           valid/ready
//  res      out        result, write_back, c/z/n/v/s flags            valid/ready
//
//  two register stages: request register, then result register
//  one request per cycle sustained while res is ready
//  the kept flags update as a request moves into the result register,
//  so the next request sees them with no bubble
//  rst_n clears both stage valids and all kept flags
//  a stalled result holds both stages; the request stage frees as results drain
module eight_bit_alu_with_status_flags_top
    import ebalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ebalu_cmd_if.sink   cmd,
    ebalu_res_if.source res
);

    request_t req_reg;
    logic     req_valid_reg;
    answer_t  ans_reg;
    logic     ans_valid_reg;
    flags_t   flags_reg;
    answer_t  ans_next;
    logic     move;
    logic     take;

    assign move      = req_valid_reg && (!ans_valid_reg || res.ready);
    assign take      = cmd.valid && cmd.ready;
    assign cmd.ready = !req_valid_reg || move;

    ebalu_core u_core (
        .req       (req_reg),
        .flags_old (flags_reg),
        .ans       (ans_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            ans_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (cmd.ready)
            begin
                req_valid_reg <= cmd.valid;
            end
            if (!ans_valid_reg || res.ready)
            begin
                ans_valid_reg <= req_valid_reg;
            end
            if (move)
            begin
                flags_reg <= ans_next.flags;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg.command       <= cmd.command;
            req_reg.left_operand  <= cmd.left_operand;
            req_reg.right_operand <= cmd.right_operand;
        end
        if (move)
        begin
            ans_reg <= ans_next;
        end
    end

    assign res.valid         = ans_valid_reg;
    assign res.result        = ans_reg.result;
    assign res.write_back    = ans_reg.write_back;
    assign res.carry_flag    = ans_reg.flags.c;
    assign res.zero_flag     = ans_reg.flags.z;
    assign res.negative_flag = ans_reg.flags.n;
    assign res.overflow_flag = ans_reg.flags.v;
    assign res.sign_flag     = ans_reg.flags.s;

    // delivered flags always match the kept flags after a move
    a_flags_track: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> (ans_reg.flags == flags_reg))
        else $error("result flags differ from kept flags");

    // sign is negative xor overflow on every delivered result
    a_sign_rule: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.sign_flag == (res.negative_flag ^ res.overflow_flag)))
        else $error("sign flag not n xor v");

    // kept flags change only when a request moves to the result stage
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !move |=> $stable(flags_reg))
        else $error("kept flags changed without a move");

    // unknown commands leave the kept flags untouched
    a_unknown_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (move && (req_reg.command > CmdW'(OP_SBIW))) |=> $stable(flags_reg))
        else $error("unknown command altered flags");

endmodule

FILE: tb/eight_bit_alu_with_status_flags_top_test.sv
// testbench for the eight-bit alu: directed table then random requests against a predictor
`timescale 1ns / 100ps

module eight_bit_alu_with_status_flags_top_test;
    import ebalu_pkg::*;

    localparam logic [CmdW-1:0] CMD_UNUSED_LO = 4'd12;
    localparam logic [CmdW-1:0] CMD_UNUSED_HI = 4'd15;
    localparam int unsigned RandomRequests = 600;

    typedef struct {
        logic [CmdW-1:0]  op;
        logic [WordW-1:0] lw;
        logic [ByteW-1:0] rb;
        bit               typed;
        answer_t          ans;
    } row_t;

    typedef struct {
        bit      typed;
        answer_t ans;
    } tag_t;

    logic clk;
    logic rst_n;
    bit   steady;
    int   mismatches = 0;

    flags_t  kept_flags = '0;
    answer_t answer_q[$];
    tag_t    tag_q[$];

    alu_op_t low_ops[3]  = '{OP_ADD, OP_SUB, OP_CP};
    alu_op_t high_ops[3] = '{OP_ADC, OP_SBC, OP_CPC};

    // flags written as s v n z c
    row_t dir_tab[24] = '{
        '{OP_ADD,        16'h0000, 8'h00, 1'b1, {16'h0000, 1'b1, 5'b00010}},
        '{OP_ADD,        16'h00FF, 8'h01, 1'b1, {16'h0000, 1'b1, 5'b00011}},
        '{OP_ADC,        16'hAAFF, 8'hFF, 1'b1, {16'h00FF, 1'b1, 5'b10101}},
        '{OP_ADD,        16'h007F, 8'h01, 1'b1, {16'h0080, 1'b1, 5'b01100}},
        '{OP_SUB,        16'h0000, 8'h01, 1'b1, {16'h00FF, 1'b1, 5'b10101}},
        '{OP_SUB,        16'h0080, 8'h01, 1'b1, {16'h007F, 1'b1, 5'b11000}},
        '{OP_SUB,        16'h0055, 8'h55, 1'b1, {16'h0000, 1'b1, 5'b00010}},
        '{OP_SBC,        16'h0010, 8'h10, 1'b1, {16'h0000, 1'b1, 5'b00010}},
        '{OP_CPC,        16'h0000, 8'h00, 1'b1, {16'h0000, 1'b0, 5'b00010}},
        '{OP_SUB,        16'h0001, 8'h00, 1'b0, '0},
        '{OP_SBC,        16'h0000, 8'h00, 1'b0, '0},
        '{OP_CP,         16'h0012, 8'h34, 1'b0, '0},
        '{OP_CPC,        16'h0034, 8'h34, 1'b0, '0},
        '{OP_AND,        16'h00F0, 8'h0F, 1'b0, '0},
        '{OP_OR,         16'h0080, 8'h00, 1'b0, '0},
        '{OP_EOR,        16'h00FF, 8'hFF, 1'b0, '0},
        '{OP_DEC,        16'h0080, 8'h00, 1'b0, '0},
        '{OP_DEC,        16'h0000, 8'h00, 1'b0, '0},
        '{OP_ADIW,       16'h7FFF, 8'h01, 1'b1, {16'h8000, 1'b1, 5'b01100}},
        '{OP_ADIW,       16'hFFFF, 8'hC1, 1'b1, {16'h0000, 1'b1, 5'b00011}},
        '{OP_SBIW,       16'h0000, 8'hFF, 1'b1, {16'hFFC1, 1'b1, 5'b10101}},
        '{OP_SBIW,       16'h8000, 8'h01, 1'b1, {16'h7FFF, 1'b1, 5'b11000}},
        '{CMD_UNUSED_LO, 16'h1234, 8'h56, 1'b0, '0},
        '{CMD_UNUSED_HI, 16'hFFFF, 8'hFF, 1'b0, '0}
    };

    ebalu_cmd_if cmd_ch ();
    ebalu_res_if res_ch ();

    eight_bit_alu_with_status_flags_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic answer_t alu_predict(input logic [CmdW-1:0] op,
                                            input logic [WordW-1:0] lw,
                                            input logic [ByteW-1:0] rb,
                                            input flags_t kept);
        answer_t          a;
        logic [ByteW-1:0] d;
        logic [ByteW-1:0] q;
        logic [WordW-1:0] w;
        logic             ci;
        logic             d7;
        logic             r7;
        logic             q7;
        logic             c;
        logic             z;
        logic             n;
        logic             v;
        d = lw[7:0];
        a.result = '0;
        a.write_back = 1'b1;
        a.flags = kept;
        c = kept.c;
        v = 1'b0;
        r7 = rb[7];
        d7 = d[7];
        case (op)
            OP_ADD, OP_ADC:
            begin
                ci = (op == OP_ADC) ? kept.c : 1'b0;
                q = d + rb + ci;
                q7 = q[7];
                c = (d7 & r7) | (r7 & ~q7) | (~q7 & d7);
                v = (d7 & r7 & ~q7) | (~d7 & ~r7 & q7);
                z = (q == 8'h00);
                n = q7;
                a.result = {8'h00, q};
            end
            OP_SUB, OP_SBC, OP_CP, OP_CPC:
            begin
                ci = (op == OP_SBC || op == OP_CPC) ? kept.c : 1'b0;
                q = d - rb - ci;
                q7 = q[7];
                c = (~d7 & r7) | (r7 & q7) | (q7 & ~d7);
                v = (d7 & ~r7 & ~q7) | (~d7 & r7 & q7);
                z = (q == 8'h00);
                if (op == OP_SBC || op == OP_CPC)
                begin
                    z = z & kept.z;
                end
                n = q7;
                a.result = {8'h00, q};
                a.write_back = !(op == OP_CP || op == OP_CPC);
            end
            OP_AND, OP_OR, OP_EOR:
            begin
                if (op == OP_AND)
                begin
                    q = d & rb;
                end
                else if (op == OP_OR)
                begin
                    q = d | rb;
                end
                else
                begin
                    q = d ^ rb;
                end
                z = (q == 8'h00);
                n = q[7];
                a.result = {8'h00, q};
            end
            OP_DEC:
            begin
                q = d - 8'h01;
                z = (q == 8'h00);
                n = q[7];
                v = (q == 8'h7F);
                a.result = {8'h00, q};
            end
            OP_ADIW, OP_SBIW:
            begin
                if (op == OP_ADIW)
                begin
                    w = lw + {10'b0, rb[ImmW-1:0]};
                    v = ~lw[15] & w[15];
                    c = ~w[15] & lw[15];
                end
                else
                begin
                    w = lw - {10'b0, rb[ImmW-1:0]};
                    v = lw[15] & ~w[15];
                    c = w[15] & ~lw[15];
                end
                z = (w == 16'h0000);
                n = w[15];
                a.result = w;
            end
            default:
            begin
                a.write_back = 1'b0;
                return a;
            end
        endcase
        a.flags.c = c;
        a.flags.z = z;
        a.flags.n = n;
        a.flags.v = v;
        a.flags.s = n ^ v;
        return a;
    endfunction

    function automatic logic [ByteW-1:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [WordW-1:0] pick_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            default: return {8'($urandom), pick_byte()};
        endcase
    endfunction

    function automatic logic [CmdW-1:0] pick_op();
        if ($urandom_range(99) < 5)
        begin
            return 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        end
        return 4'($urandom_range(OP_SBIW, OP_ADD));
    endfunction

    task automatic send_request(input logic [CmdW-1:0] op, input logic [WordW-1:0] lw,
                                input logic [ByteW-1:0] rb, input bit typed,
                                input answer_t ans);
        if (!steady && $urandom_range(99) < 20)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        tag_q.push_back('{typed, ans});
        cmd_ch.valid         <= 1'b1;
        cmd_ch.command       <= op;
        cmd_ch.left_operand  <= lw;
        cmd_ch.right_operand <= rb;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // predict on every accepted request
    always @(posedge clk)
    begin : predict_requests
        answer_t pred;
        tag_t    tag;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            pred = alu_predict(cmd_ch.command, cmd_ch.left_operand,
                               cmd_ch.right_operand, kept_flags);
            kept_flags = pred.flags;
            tag = tag_q.pop_front();
            answer_q.push_back(tag.typed ? tag.ans : pred);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= steady || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge clk)
    begin : check_results
        answer_t got;
        answer_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.result     = res_ch.result;
            got.write_back = res_ch.write_back;
            got.flags.s    = res_ch.sign_flag;
            got.flags.v    = res_ch.overflow_flag;
            got.flags.n    = res_ch.negative_flag;
            got.flags.z    = res_ch.zero_flag;
            got.flags.c    = res_ch.carry_flag;
            if (answer_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result r=%h wb=%b svnzc=%b",
                             got.result, got.write_back, got.flags);
                end
            end
            else
            begin
                want = answer_q.pop_front();
                if (got.result !== want.result || got.write_back !== want.write_back ||
                    got.flags.c !== want.flags.c || got.flags.z !== want.flags.z ||
                    got.flags.n !== want.flags.n || got.flags.v !== want.flags.v ||
                    got.flags.s !== want.flags.s)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: want r=%h wb=%b svnzc=%b, got r=%h wb=%b svnzc=%b",
                                 want.result, want.write_back, want.flags,
                                 got.result, got.write_back, got.flags);
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned k;
        rst_n                = 1'b0;
        steady               = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.command       = '0;
        cmd_ch.left_operand  = '0;
        cmd_ch.right_operand = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            send_request(dir_tab[i].op, dir_tab[i].lw, dir_tab[i].rb,
                         dir_tab[i].typed, dir_tab[i].ans);
        end

        n = 0;
        while (n < RandomRequests)
        begin
            steady = (n >= 250 && n < 400);
            if ($urandom_range(3) == 0)
            begin
                // low byte then high byte through the kept carry
                k = $urandom_range(2);
                send_request(low_ops[k], pick_word(), pick_byte(), 1'b0, '0);
                send_request(high_ops[k], pick_word(), pick_byte(), 1'b0, '0);
                n += 2;
            end
            else
            begin
                send_request(pick_op(), pick_word(), pick_byte(), 1'b0, '0);
                n++;
            end
        end
        cmd_ch.valid <= 1'b0;
        steady = 1'b0;

        while (answer_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ebalu_pkg.sv
rtl/ebalu_cmd_if.sv
rtl/ebalu_res_if.sv
rtl/ebalu_core.sv
rtl/eight_bit_alu_with_status_flags_top.sv
tb/eight_bit_alu_with_status_flags_top_test.sv
